// File: rtl/mpsn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsn_pkg: shared types and constants of the masked pattern scanner
// Sizes of the pattern store and the byte window, command and register
// codes, and the word formats of the input and result channels.
// ----------------------------------------------------------------------------
package mpsn_pkg;

  localparam int PATTERN_MAX  = 48;
  localparam int WINDOW_DEPTH = 64;
  localparam int WORD_BYTES   = 4;
  localparam int BYTE_W       = 8;
  localparam int ADDR_W       = 32;

  // Index of one window cell, and a fill count that can hold the depth itself.
  localparam int AGE_W  = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

  // Width of the small window arithmetic (need, fill, drain step); it holds
  // a full window plus the largest need with room to spare.
  localparam int KV_W = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 3'd0,
    CFG_OCCURRENCE     = 3'd1,
    CFG_WORD_OFFSET    = 3'd2,
    CFG_RELATIVE_MODE  = 3'd3,
    CFG_DEREF_POINTER  = 3'd4
  } cfg_reg_t;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic       command;
    logic [5:0] pattern_index;
    byte_t      byte_value;
    logic       must_match;
    addr_t      byte_address;
    logic       last_byte;
  } mpsn_in_t;

  typedef struct packed {
    logic  found;
    addr_t result_value;
    addr_t match_address;
    logic  pointer_read_needed;
  } mpsn_out_t;

endpackage

// File: rtl/mpsn_win_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsn_win_cell: one byte cell of the scan window
// Holds one byte and takes its neighbor's byte on every shift.
// ----------------------------------------------------------------------------
module mpsn_win_cell
  import mpsn_pkg::*;
(
  input  logic  clk,
  input  logic  shift_en,
  input  byte_t d_in,
  output byte_t q,
  output byte_t q_nxt
);

  byte_t q_r;

  // The value after this cycle's shift, so the compare sees the new window.
  assign q_nxt = shift_en ? d_in : q_r;
  assign q     = q_r;

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

// File: rtl/mpsn_pat_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsn_pat_cell: one pattern position with its compare
// Stores a pattern byte and its care bit and compares one window byte.
// ----------------------------------------------------------------------------
module mpsn_pat_cell
  import mpsn_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  logic  wr_care,
  input  byte_t wr_byte,
  input  byte_t tap_byte,
  output logic  hit
);

  byte_t pat_r;
  logic  care_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      care_r <= 1'b0;
    end else if (wr_en) begin
      care_r <= wr_care;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_r <= wr_byte;
    end
  end

  // A wildcard position always hits.
  assign hit = !care_r || (tap_byte == pat_r);

endmodule

// File: rtl/masked_pattern_scan_nth_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_pattern_scan_nth_match: wildcard byte pattern scanner, Nth match
// Scans a byte stream for a masked pattern and reports the selected match.
// ----------------------------------------------------------------------------
// The block takes one word per cycle on its input channel: either a pattern
// load (a byte and its care bit for one pattern position) or a memory byte of
// the region being scanned. Memory bytes shift into a row of 64 window cells,
// newest first, and in the same cycle the pattern cells compare the candidate
// start that has just received every byte it needs, so a region streams at
// one byte per cycle. Matches may overlap; the first `occurrence` matches are
// counted and skipped, and the next one is reported as its address, as the
// little-endian 32-bit word at match plus word_offset, or in relative mode as
// match plus word_offset plus 4 plus that word. After a report the remaining
// bytes of the region are taken and dropped, and the last byte gives no second
// result. When the last byte arrives without a report, the starts that still
// fit in the region are judged one per cycle by shifting empty bytes through
// the window: this drain judges K - pattern_length starts, at most 64, where K
// is the larger of the pattern length and the end of the word read. During the
// drain no input word is taken, and it ends with a report or with not-found.
// A word is taken only while the result register is empty or being read, so
// a result that is not taken holds the input. A result is produced in the
// cycle after the byte (or drain step) that decides it. Configuration writes
// are taken in every cycle and must only be made while the block is idle;
// register indexes beyond the list are ignored. pointer_read_needed echoes
// deref_pointer: the dereference itself is left to outside logic.
// ----------------------------------------------------------------------------
module masked_pattern_scan_nth_match
  import mpsn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  mpsn_in_t              in_data,

  output logic                  out_valid,
  input  logic                  out_ready,
  output mpsn_out_t             out_data,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic {
    ST_SCAN,
    ST_TAIL
  } state_t;

  // Configuration registers.
  logic [5:0]  len_r;
  logic [15:0] occ_r;
  logic [5:0]  wo_r;
  logic        rel_r;
  logic        deref_r;

  // Scan control state.
  state_t            state_r,     state_nxt;
  logic [FILL_W-1:0] fill_r,      fill_nxt;
  logic [15:0]       count_r,     count_nxt;
  logic              done_r,      done_nxt;
  logic [KV_W-1:0]   t_r,         t_nxt;
  addr_t             ba_r,        ba_nxt;
  logic              out_valid_r, out_valid_nxt;
  mpsn_out_t         out_data_r,  out_data_nxt;

  logic              load_res;
  logic              clear_scan;

  // -------------------------------------------------------------------------
  // Configuration port. Writes are accepted in every cycle.
  // -------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= 6'd1;
      occ_r   <= 16'd0;
      wo_r    <= 6'd0;
      rel_r   <= 1'b0;
      deref_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PATTERN_LENGTH: len_r   <= cfg_data[5:0];
        CFG_OCCURRENCE:     occ_r   <= cfg_data[15:0];
        CFG_WORD_OFFSET:    wo_r    <= cfg_data[5:0];
        CFG_RELATIVE_MODE:  rel_r   <= cfg_data[0];
        CFG_DEREF_POINTER:  deref_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Derived sizes. The pattern length is capped at the store depth. A word is
  // read when relative mode is on or the offset is nonzero, and the need K is
  // the larger of the pattern length and the word end, at least one byte.
  // -------------------------------------------------------------------------
  logic            uses_word;
  logic [KV_W-1:0] len_k;
  logic [KV_W-1:0] we_k;
  logic [KV_W-1:0] kv;

  assign uses_word = rel_r || (wo_r != 6'd0);
  assign len_k = (KV_W'(len_r) > KV_W'(PATTERN_MAX)) ? KV_W'(PATTERN_MAX) : KV_W'(len_r);
  assign we_k  = uses_word ? (KV_W'(wo_r) + KV_W'(WORD_BYTES)) : '0;

  always_comb begin
    kv = len_k;
    if (we_k > kv) begin
      kv = we_k;
    end
    if (kv == '0) begin
      kv = KV_W'(1);
    end
  end

  // -------------------------------------------------------------------------
  // Handshakes and the shift of the window.
  // -------------------------------------------------------------------------
  logic in_acc;
  logic out_free;
  logic byte_go;
  logic skip_go;
  logic load_go;
  logic tail_adv;
  logic shift_en;
  byte_t shift_byte;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_SCAN) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign byte_go  = in_acc && (in_data.command == CMD_BYTE) && !done_r;
  assign skip_go  = in_acc && (in_data.command == CMD_BYTE) && done_r;
  assign load_go  = in_acc && (in_data.command == CMD_LOAD) &&
                    (KV_W'(in_data.pattern_index) < KV_W'(PATTERN_MAX));
  assign tail_adv = (state_r == ST_TAIL) && out_free;

  // During the drain, empty bytes push the remaining starts into place.
  assign shift_en   = byte_go || tail_adv;
  assign shift_byte = (state_r == ST_TAIL) ? '0 : in_data.byte_value;

  // Window cells: cell a holds the byte that arrived a bytes ago.
  byte_t win_q [WINDOW_DEPTH];
  byte_t view  [WINDOW_DEPTH];

  for (genvar a = 0; a < WINDOW_DEPTH; a++) begin : g_win
    if (a == 0) begin : g_head
      mpsn_win_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (shift_byte),
        .q        (win_q[a]),
        .q_nxt    (view[a])
      );
    end else begin : g_body
      mpsn_win_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (win_q[a-1]),
        .q        (win_q[a]),
        .q_nxt    (view[a])
      );
    end
  end

  // -------------------------------------------------------------------------
  // Candidate judgement. The candidate start sits K-1 bytes behind the
  // newest byte, so pattern position c looks at cell K-1-c. In the drain,
  // t counts the empty bytes shifted in so far.
  // -------------------------------------------------------------------------
  logic [KV_W-1:0] t_k;
  logic [KV_W-1:0] fill_k;
  logic [FILL_W-1:0] fill_inc;
  logic            in_win;
  logic            cand_ok;
  logic            word_fit;

  assign fill_inc = (fill_r == FILL_W'(WINDOW_DEPTH)) ? fill_r : fill_r + FILL_W'(1);
  assign t_k      = (state_r == ST_TAIL) ? t_r : '0;
  assign fill_k   = (state_r == ST_TAIL) ? KV_W'(fill_r) : KV_W'(fill_inc);
  assign in_win   = (kv <= KV_W'(WINDOW_DEPTH));
  // The start must be a byte of the region and its pattern must fit in it.
  assign cand_ok  = (kv <= fill_k + t_k) && (len_k + t_k <= kv);
  // The word of a start near the end may run past the last byte.
  assign word_fit = (t_k + we_k <= kv);

  logic [PATTERN_MAX-1:0] pos_ok;
  logic                   pat_hit;

  for (genvar c = 0; c < PATTERN_MAX; c++) begin : g_pat
    logic [KV_W-1:0] tap_idx;
    byte_t           tap;
    logic            cell_hit;
    logic            wr_en;

    assign tap_idx = kv - KV_W'(1) - KV_W'(c);
    assign tap     = (tap_idx < KV_W'(WINDOW_DEPTH)) ? view[tap_idx[AGE_W-1:0]] : '0;
    assign wr_en   = load_go && (KV_W'(in_data.pattern_index) == KV_W'(c));

    mpsn_pat_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_en),
      .wr_care  (in_data.must_match),
      .wr_byte  (in_data.byte_value),
      .tap_byte (tap),
      .hit      (cell_hit)
    );

    // Positions past the pattern length take part in no compare.
    assign pos_ok[c] = (KV_W'(c) >= len_k) || cell_hit;
  end

  assign pat_hit = &pos_ok;

  // The word is little-endian: its lowest address is the oldest byte.
  addr_t word;

  for (genvar j = 0; j < WORD_BYTES; j++) begin : g_word
    logic [KV_W-1:0] tap_idx;

    assign tap_idx = kv - KV_W'(1) - KV_W'(wo_r) - KV_W'(j);
    assign word[BYTE_W*j +: BYTE_W] =
      (tap_idx < KV_W'(WINDOW_DEPTH)) ? view[tap_idx[AGE_W-1:0]] : '0;
  end

  // Match address is the byte address minus (K-1-t); the relative target adds
  // the offset, four and the word. The small terms are folded first.
  addr_t          ba_j;
  logic [KV_W:0]  addr_dlt;
  logic [KV_W:0]  rel_dlt;
  addr_t          match_addr;
  addr_t          rel_val;
  addr_t          res_val;
  logic           found_w;
  logic           judge_go;
  logic           hit_cnt;
  logic           report;
  mpsn_out_t      res_hit;

  assign ba_j     = (state_r == ST_TAIL) ? ba_r : in_data.byte_address;
  assign addr_dlt = {1'b0, t_k} + (KV_W+1)'(1) - {1'b0, kv};
  assign rel_dlt  = {1'b0, t_k} + (KV_W+1)'(wo_r) + (KV_W+1)'(WORD_BYTES + 1) - {1'b0, kv};

  assign match_addr = ba_j + {{(ADDR_W-KV_W-1){addr_dlt[KV_W]}}, addr_dlt};
  assign rel_val    = ba_j + word + {{(ADDR_W-KV_W-1){rel_dlt[KV_W]}}, rel_dlt};

  always_comb begin
    if (!uses_word) begin
      res_val = match_addr;
    end else if (rel_r) begin
      res_val = rel_val;
    end else begin
      res_val = word;
    end
  end

  assign found_w  = !uses_word || word_fit;
  assign judge_go = shift_en && in_win && cand_ok && pat_hit;
  assign hit_cnt  = judge_go && (count_r < occ_r);
  assign report   = judge_go && !(count_r < occ_r);

  always_comb begin
    res_hit.found               = found_w;
    res_hit.result_value        = found_w ? res_val : '0;
    res_hit.match_address       = found_w ? match_addr : '0;
    res_hit.pointer_read_needed = found_w && deref_r;
  end

  // -------------------------------------------------------------------------
  // Scan control: stream state, drain sequencing and the result register.
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    done_nxt      = done_r;
    t_nxt         = t_r;
    ba_nxt        = ba_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    load_res      = 1'b0;
    clear_scan    = 1'b0;

    if (hit_cnt) begin
      count_nxt = count_r + 16'd1;
    end

    case (state_r)
      ST_SCAN: begin
        if (byte_go) begin
          fill_nxt = fill_inc;
          ba_nxt   = in_data.byte_address;
          if (report) begin
            load_res     = 1'b1;
            out_data_nxt = res_hit;
            if (in_data.last_byte) begin
              clear_scan = 1'b1;
            end else begin
              done_nxt = 1'b1;
            end
          end else if (in_data.last_byte) begin
            if (in_win && (len_k < kv)) begin
              state_nxt = ST_TAIL;
              t_nxt     = KV_W'(1);
            end else begin
              load_res     = 1'b1;
              out_data_nxt = '0;
              clear_scan   = 1'b1;
            end
          end
        end else if (skip_go && in_data.last_byte) begin
          clear_scan = 1'b1;
        end
      end
      ST_TAIL: begin
        if (tail_adv) begin
          if (report) begin
            load_res     = 1'b1;
            out_data_nxt = res_hit;
            clear_scan   = 1'b1;
            state_nxt    = ST_SCAN;
          end else if (t_r + len_k >= kv) begin
            load_res     = 1'b1;
            out_data_nxt = '0;
            clear_scan   = 1'b1;
            state_nxt    = ST_SCAN;
          end else begin
            t_nxt = t_r + KV_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_SCAN;
      end
    endcase

    if (load_res) begin
      out_valid_nxt = 1'b1;
    end

    if (clear_scan) begin
      fill_nxt  = '0;
      count_nxt = '0;
      done_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SCAN;
      fill_r      <= '0;
      count_r     <= '0;
      done_r      <= 1'b0;
      t_r         <= '0;
      ba_r        <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      t_r         <= t_nxt;
      ba_r        <= ba_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill count exceeds the window depth");

  a_tail_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAIL) |-> ((t_r != '0) && (t_r + len_k <= kv) && !done_r))
    else $error("drain step out of range or drain after a report");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_res |-> out_free)
    else $error("result loaded while the previous one is still held");

  a_tail_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_TAIL) && (state_nxt == ST_SCAN)) |=>
      ((fill_r == '0) && (count_r == '0) && out_valid_r))
    else $error("drain ended without a result or without clearing the scan");

endmodule
